/* rtl/ctsc_pkg.sv */
// Package for the CAN transport session controller.
// Holds shared codes, the queued command beat and the result beat types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctsc_pkg;

  // Default bound on segments per session
  localparam int MAX_SEGMENTS_DEF = 1024;

  // Frame kinds
  localparam logic [1:0] FT_SINGLE = 2'd0;
  localparam logic [1:0] FT_FIRST  = 2'd1;
  localparam logic [1:0] FT_CONSEC = 2'd2;
  localparam logic [1:0] FT_FLOW   = 2'd3;

  // Flow control status
  localparam logic [1:0] FS_CONT     = 2'd0;
  localparam logic [1:0] FS_WAIT     = 2'd1;
  localparam logic [1:0] FS_OVERFLOW = 2'd2;

  // Send kinds
  localparam logic [1:0] SK_NONE = 2'd0;
  localparam logic [1:0] SK_SEGS = 2'd1;
  localparam logic [1:0] SK_FC   = 2'd2;

  // Session end codes
  localparam logic [1:0] END_NONE = 2'd0;
  localparam logic [1:0] END_DONE = 2'd1;
  localparam logic [1:0] END_ERR  = 2'd2;

  // Classified beat handed from front to back
  typedef struct packed {
    logic        is_req;
    logic [1:0]  ftype;
    logic [11:0] mlen;
    logic [3:0]  seq;
    logic [1:0]  fstat;
    logic [7:0]  bsize;
    logic [7:0]  gap;
    logic [10:0] nseg;
    logic        req_bad;   // empty, oversized or wrong-kind request
    logic        bs_zero;   // block size zero: send all remaining
  } cmd_t;

  // Result beat
  typedef struct packed {
    logic [1:0]  send_kind;
    logic [9:0]  first_segment;
    logic [10:0] segment_count;
    logic [7:0]  gap_ms;
    logic [1:0]  session_end;
    logic        deliver_rx;
    logic [10:0] rx_segments;
  } res_t;

endpackage

`default_nettype wire

/* rtl/ctsc_fifo.sv */
// Two-entry queue used between stages of the session controller.
// Generic data width; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module ctsc_fifo #(
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [DW-1:0] wr_data,
  output logic               full,
  input  wire logic          rd_en,
  output logic [DW-1:0]      rd_data,
  output logic               empty
);

  logic [DW-1:0] mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_wr ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/ctsc_front.sv */
// Front end: accepts input beats, classifies them and queues them for the back end.
// Depends on ctsc_pkg and ctsc_fifo.
`timescale 1ns / 1ps
`default_nettype none

module ctsc_front #(
  parameter int MAX_SEGMENTS = ctsc_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  output logic                full,
  input  wire logic           in_command,
  input  wire logic [1:0]     in_frame_type,
  input  wire logic [11:0]    in_message_length,
  input  wire logic [3:0]     in_seq_num,
  input  wire logic [1:0]     in_flow_status,
  input  wire logic [7:0]     in_block_size,
  input  wire logic [7:0]     in_min_sep_time,
  input  wire logic [10:0]    in_tx_segment_count,
  input  wire logic           cq_pop,
  output ctsc_pkg::cmd_t      cq_data,
  output logic                cq_empty
);

  import ctsc_pkg::*;

  cmd_t             cmd;
  logic [$bits(cmd_t)-1:0] cq_raw;

  // Classify the beat
  always_comb begin
    cmd.is_req  = in_command;
    cmd.ftype   = in_frame_type;
    cmd.mlen    = in_message_length;
    cmd.seq     = in_seq_num;
    cmd.fstat   = in_flow_status;
    cmd.bsize   = in_block_size;
    cmd.gap     = in_min_sep_time;
    cmd.nseg    = in_tx_segment_count;
    cmd.req_bad = (in_tx_segment_count == 11'd0) ||
                  (32'(in_tx_segment_count) > 32'(MAX_SEGMENTS)) ||
                  ((in_frame_type != FT_SINGLE) && (in_frame_type != FT_FIRST));
    cmd.bs_zero = (in_block_size == 8'd0);
  end

  ctsc_fifo #(
    .DW($bits(cmd_t))
  ) u_cq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (cmd),
    .full    (full),
    .rd_en   (cq_pop),
    .rd_data (cq_raw),
    .empty   (cq_empty)
  );

  assign cq_data = cmd_t'(cq_raw);

endmodule

`default_nettype wire

/* rtl/ctsc_back.sv */
// Back end: session state machine, one queued beat per cycle while the result queue has room, results into a queue.
// Depends on ctsc_pkg and ctsc_fifo.
`timescale 1ns / 1ps
`default_nettype none

module ctsc_back #(
  parameter int MAX_SEGMENTS = ctsc_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire ctsc_pkg::cmd_t cq_data,
  input  wire logic           cq_empty,
  output logic                cq_pop,
  input  wire logic           pop,
  output logic                empty,
  output ctsc_pkg::res_t      res
);

  import ctsc_pkg::*;

  localparam int RCW = $clog2(MAX_SEGMENTS + 1);
  localparam int LW  = (RCW + 4 > 13) ? RCW + 4 : 13;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_TX   = 3'b010,
    MODE_RX   = 3'b100
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic [10:0]      tx_next_r, tx_next_nxt;
  logic [10:0]      tx_total_r, tx_total_nxt;
  logic [3:0]       exp_seq_r, exp_seq_nxt;
  logic [11:0]      rx_len_r, rx_len_nxt;
  logic [RCW-1:0]   rx_count_r, rx_count_nxt;

  res_t             r;
  logic             oq_full;
  logic             step;
  logic [10:0]      left, cnt, tx_sum;
  logic [3:0]       seq_inc;
  logic [RCW-1:0]   rx_inc;
  logic [LW-1:0]    reach;
  logic [$bits(res_t)-1:0] oq_raw;

  assign step   = !cq_empty && !oq_full;
  assign cq_pop = step;

  // Burst sizing and receive bookkeeping
  always_comb begin
    left    = (tx_next_r < tx_total_r) ? (tx_total_r - tx_next_r) : 11'd0;
    cnt     = (cq_data.bs_zero || (11'(cq_data.bsize) > left)) ? left : 11'(cq_data.bsize);
    tx_sum  = tx_next_r + cnt;
    seq_inc = exp_seq_r + 4'd1;
    rx_inc  = rx_count_r + RCW'(1);
    // 6 + 7 * (frames before this one)
    reach   = LW'({rx_count_r, 3'b000}) - LW'(rx_count_r) + LW'(6);
  end

  // Session decisions
  always_comb begin
    mode_nxt     = mode_r;
    tx_next_nxt  = tx_next_r;
    tx_total_nxt = tx_total_r;
    exp_seq_nxt  = exp_seq_r;
    rx_len_nxt   = rx_len_r;
    rx_count_nxt = rx_count_r;
    r            = '0;

    if (cq_data.is_req) begin
      // A request drops any busy session
      if (mode_r == MODE_RX) begin
        r.deliver_rx  = 1'b1;
        r.rx_segments = 11'(rx_count_r);
      end
      mode_nxt = MODE_IDLE;
      if (cq_data.req_bad) begin
        r.session_end = END_ERR;
      end else begin
        r.send_kind     = SK_SEGS;
        r.segment_count = 11'd1;
        if (cq_data.ftype == FT_SINGLE) begin
          r.session_end = END_DONE;
        end else begin
          mode_nxt     = MODE_TX;
          tx_total_nxt = cq_data.nseg;
          tx_next_nxt  = 11'd1;
        end
      end
    end else begin
      case (mode_r)
        MODE_TX: begin
          if (cq_data.ftype != FT_FLOW || cq_data.fstat == FS_WAIT) begin
            // ignored frame
          end else if (cq_data.fstat == FS_OVERFLOW) begin
            mode_nxt      = MODE_IDLE;
            r.session_end = END_ERR;
          end else if (cnt == 11'd0) begin
            mode_nxt      = MODE_IDLE;
            r.session_end = END_DONE;
          end else begin
            r.send_kind     = SK_SEGS;
            r.first_segment = tx_next_r[9:0];
            r.segment_count = cnt;
            r.gap_ms        = cq_data.gap;
            tx_next_nxt     = tx_sum;
            if (tx_sum >= tx_total_r) begin
              mode_nxt      = MODE_IDLE;
              r.session_end = END_DONE;
            end
          end
        end
        MODE_RX: begin
          if (cq_data.ftype != FT_CONSEC ||
              rx_count_r >= RCW'(MAX_SEGMENTS)) begin
            mode_nxt      = MODE_IDLE;
            r.session_end = END_ERR;
            r.deliver_rx  = 1'b1;
            r.rx_segments = 11'(rx_count_r);
          end else begin
            exp_seq_nxt  = seq_inc;
            rx_count_nxt = rx_inc;
            if (seq_inc != cq_data.seq) begin
              mode_nxt      = MODE_IDLE;
              r.session_end = END_ERR;
              r.deliver_rx  = 1'b1;
              r.rx_segments = 11'(rx_inc);
            end else if (reach >= LW'(rx_len_r)) begin
              mode_nxt      = MODE_IDLE;
              r.session_end = END_DONE;
              r.deliver_rx  = 1'b1;
              r.rx_segments = 11'(rx_inc);
            end
          end
        end
        default: begin
          // idle: single or first frame may open reception
          if (cq_data.ftype == FT_SINGLE) begin
            rx_count_nxt  = RCW'(1);
            r.session_end = END_DONE;
            r.deliver_rx  = 1'b1;
            r.rx_segments = 11'd1;
          end else if (cq_data.ftype == FT_FIRST) begin
            mode_nxt      = MODE_RX;
            rx_count_nxt  = RCW'(1);
            rx_len_nxt    = cq_data.mlen;
            exp_seq_nxt   = 4'd0;
            r.send_kind   = SK_FC;
          end else begin
            r.session_end = END_ERR;
          end
        end
      endcase
    end
  end

  // Session state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      tx_next_r  <= 11'd0;
      tx_total_r <= 11'd0;
      exp_seq_r  <= 4'd0;
      rx_len_r   <= 12'd0;
      rx_count_r <= '0;
    end else if (step) begin
      mode_r     <= mode_nxt;
      tx_next_r  <= tx_next_nxt;
      tx_total_r <= tx_total_nxt;
      exp_seq_r  <= exp_seq_nxt;
      rx_len_r   <= rx_len_nxt;
      rx_count_r <= rx_count_nxt;
    end
  end

  // Result queue
  ctsc_fifo #(
    .DW($bits(res_t))
  ) u_oq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (step),
    .wr_data (r),
    .full    (oq_full),
    .rd_en   (pop),
    .rd_data (oq_raw),
    .empty   (empty)
  );

  assign res = res_t'(oq_raw);

endmodule

`default_nettype wire

/* rtl/can_transport_session_control.sv */
// Top level of the CAN transport session controller.
// Depends on ctsc_pkg, ctsc_front and ctsc_back.
//
//   channel   handshake        fields
//   input     push / full      in_command .. in_tx_segment_count
//   result    empty / pop      out_send_kind .. out_rx_segments
//
// One result per input beat, sustained one beat per cycle while results are popped.
// An accepted beat lands in the command queue, and its result is then written
// into the result queue once that queue has room.
// Both queues hold two beats.
// Synchronous reset returns the session to idle with all counters cleared.
// A stalled result side fills the result queue, then the command queue, then
// raises full.
`timescale 1ns / 1ps
`default_nettype none

module can_transport_session_control #(
  parameter int MAX_SEGMENTS = ctsc_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic        in_command,
  input  wire logic [1:0]  in_frame_type,
  input  wire logic [11:0] in_message_length,
  input  wire logic [3:0]  in_seq_num,
  input  wire logic [1:0]  in_flow_status,
  input  wire logic [7:0]  in_block_size,
  input  wire logic [7:0]  in_min_sep_time,
  input  wire logic [10:0] in_tx_segment_count,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       out_send_kind,
  output logic [9:0]       out_first_segment,
  output logic [10:0]      out_segment_count,
  output logic [7:0]       out_gap_ms,
  output logic [1:0]       out_session_end,
  output logic             out_deliver_rx,
  output logic [10:0]      out_rx_segments
);

  import ctsc_pkg::*;

  cmd_t cq_data;
  logic cq_empty;
  logic cq_pop;
  res_t res;

  ctsc_front #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_command          (in_command),
    .in_frame_type       (in_frame_type),
    .in_message_length   (in_message_length),
    .in_seq_num          (in_seq_num),
    .in_flow_status      (in_flow_status),
    .in_block_size       (in_block_size),
    .in_min_sep_time     (in_min_sep_time),
    .in_tx_segment_count (in_tx_segment_count),
    .cq_pop              (cq_pop),
    .cq_data             (cq_data),
    .cq_empty            (cq_empty)
  );

  ctsc_back #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_data  (cq_data),
    .cq_empty (cq_empty),
    .cq_pop   (cq_pop),
    .pop      (pop),
    .empty    (empty),
    .res      (res)
  );

  // Result beat onto ports
  assign out_send_kind     = res.send_kind;
  assign out_first_segment = res.first_segment;
  assign out_segment_count = res.segment_count;
  assign out_gap_ms        = res.gap_ms;
  assign out_session_end   = res.session_end;
  assign out_deliver_rx    = res.deliver_rx;
  assign out_rx_segments   = res.rx_segments;

endmodule

`default_nettype wire

/* dv/session_scoreboard.sv */
// Scoreboard for the CAN transport session controller testbench.
// Holds the frame beat type and a session predictor with its result queue.
// Depends on ctsc_pkg.
`timescale 1ns / 1ps

package session_sb_pkg;

  import ctsc_pkg::*;

  // Segment bound the block is built with
  localparam int SEG_LIMIT = MAX_SEGMENTS_DEF;

  // Reserved flow status, handled like continue
  localparam logic [1:0] FS_RESERVED = 2'd3;

  typedef enum logic [1:0] {S_IDLE, S_SEND, S_RECV} session_t;

  // One input beat: a received frame or a transmit request
  typedef struct packed {
    logic        cmd;
    logic [1:0]  ftype;
    logic [11:0] mlen;
    logic [3:0]  seq;
    logic [1:0]  fstat;
    logic [7:0]  bsize;
    logic [7:0]  gap;
    logic [10:0] nseg;
  } frame_beat_t;

  class session_scoreboard;
    session_t    mode;
    int unsigned tx_next;
    int unsigned tx_total;
    int unsigned rx_cnt;
    logic [3:0]  rx_seq;
    logic [11:0] rx_len;
    res_t        result_q[$];
    int          errors;

    function new();
      mode     = S_IDLE;
      tx_next  = 0;
      tx_total = 0;
      rx_cnt   = 0;
      rx_seq   = '0;
      rx_len   = '0;
      errors   = 0;
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    // Advance the session by one accepted beat and queue the result it owes
    function void note_input(frame_beat_t b);
      res_t        r;
      int unsigned left;
      int unsigned cnt;
      r = '0;
      if (b.cmd) begin
        // a request drops whatever was running; a dropped receive delivers
        if (mode == S_RECV) begin
          r.deliver_rx  = 1'b1;
          r.rx_segments = 11'(rx_cnt);
        end
        mode = S_IDLE;
        if (b.nseg == 0 || b.nseg > SEG_LIMIT || b.ftype > FT_FIRST) begin
          r.session_end = END_ERR;
        end else begin
          r.send_kind     = SK_SEGS;
          r.segment_count = 11'd1;
          if (b.ftype == FT_SINGLE) begin
            r.session_end = END_DONE;
          end else begin
            mode     = S_SEND;
            tx_total = b.nseg;
            tx_next  = 1;
          end
        end
      end else if (mode == S_SEND) begin
        // only flow control other than wait moves a transmit session
        if (b.ftype == FT_FLOW && b.fstat != FS_WAIT) begin
          if (b.fstat == FS_OVERFLOW) begin
            mode          = S_IDLE;
            r.session_end = END_ERR;
          end else begin
            left = (tx_next < tx_total) ? tx_total - tx_next : 0;
            cnt  = (b.bsize == 0 || b.bsize > left) ? left : b.bsize;
            if (cnt == 0) begin
              mode          = S_IDLE;
              r.session_end = END_DONE;
            end else begin
              r.send_kind     = SK_SEGS;
              r.first_segment = 10'(tx_next);
              r.segment_count = 11'(cnt);
              r.gap_ms        = b.gap;
              tx_next         = tx_next + cnt;
              if (tx_next >= tx_total) begin
                mode          = S_IDLE;
                r.session_end = END_DONE;
              end
            end
          end
        end
      end else if (mode == S_RECV) begin
        // error with delivery unless a good consecutive frame keeps it going
        mode          = S_IDLE;
        r.session_end = END_ERR;
        r.deliver_rx  = 1'b1;
        r.rx_segments = 11'(rx_cnt);
        if (b.ftype == FT_CONSEC && rx_cnt < SEG_LIMIT) begin
          rx_seq        = rx_seq + 4'd1;
          rx_cnt        = rx_cnt + 1;
          r.rx_segments = 11'(rx_cnt);
          if (rx_seq == b.seq) begin
            if (6 + (rx_cnt - 1) * 7 >= rx_len) begin
              r.session_end = END_DONE;
            end else begin
              r    = '0;
              mode = S_RECV;
            end
          end
        end
      end else begin
        // idle: single frame is a whole message, first frame opens a receive
        case (b.ftype)
          FT_SINGLE: begin
            rx_cnt        = 1;
            r.session_end = END_DONE;
            r.deliver_rx  = 1'b1;
            r.rx_segments = 11'd1;
          end
          FT_FIRST: begin
            mode        = S_RECV;
            rx_cnt      = 1;
            rx_len      = b.mlen;
            rx_seq      = '0;
            r.send_kind = SK_FC;
          end
          default: r.session_end = END_ERR;
        endcase
      end
      result_q.insert(result_q.size(), r);
    endfunction

    function string show(res_t r);
      return $sformatf("kind %0d first %0d count %0d gap %0d end %0d deliver %0d segs %0d",
                       r.send_kind, r.first_segment, r.segment_count, r.gap_ms,
                       r.session_end, r.deliver_rx, r.rx_segments);
    endfunction

    // Compare one popped result beat with the oldest prediction
    function void check_result(res_t got);
      res_t want;
      if (result_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result beat with nothing expected: %s", show(got));
        return;
      end
      want = result_q.pop_front();
      if (got.send_kind !== want.send_kind || got.first_segment !== want.first_segment ||
          got.segment_count !== want.segment_count || got.gap_ms !== want.gap_ms ||
          got.session_end !== want.session_end || got.deliver_rx !== want.deliver_rx ||
          got.rx_segments !== want.rx_segments) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected %s", show(want));
          $display("          actual   %s", show(got));
        end
      end
    endfunction
  endclass

endpackage

/* dv/tb.sv */
// Testbench top for can_transport_session_control.
// Drives frames and requests, pops results and checks them against the
// session predictor in session_sb_pkg; depends on ctsc_pkg.
`timescale 1ns / 1ps

module tb;

  import ctsc_pkg::*;
  import session_sb_pkg::*;

  localparam int ITEM_TARGET = 850;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        in_command = 1'b0;
  logic [1:0]  in_frame_type = '0;
  logic [11:0] in_message_length = '0;
  logic [3:0]  in_seq_num = '0;
  logic [1:0]  in_flow_status = '0;
  logic [7:0]  in_block_size = '0;
  logic [7:0]  in_min_sep_time = '0;
  logic [10:0] in_tx_segment_count = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  out_send_kind;
  logic [9:0]  out_first_segment;
  logic [10:0] out_segment_count;
  logic [7:0]  out_gap_ms;
  logic [1:0]  out_session_end;
  logic        out_deliver_rx;
  logic [10:0] out_rx_segments;

  res_t              out_beat;
  session_scoreboard sb;
  int                items_sent = 0;
  int                idle_odds = 0;
  int                pop_odds = 0;
  int                stall_left = 0;
  int                cycle_count = 0;
  logic              quiet = 1'b0;

  can_transport_session_control #(.MAX_SEGMENTS(SEG_LIMIT)) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_command          (in_command),
    .in_frame_type       (in_frame_type),
    .in_message_length   (in_message_length),
    .in_seq_num          (in_seq_num),
    .in_flow_status      (in_flow_status),
    .in_block_size       (in_block_size),
    .in_min_sep_time     (in_min_sep_time),
    .in_tx_segment_count (in_tx_segment_count),
    .empty               (empty),
    .pop                 (pop),
    .out_send_kind       (out_send_kind),
    .out_first_segment   (out_first_segment),
    .out_segment_count   (out_segment_count),
    .out_gap_ms          (out_gap_ms),
    .out_session_end     (out_session_end),
    .out_deliver_rx      (out_deliver_rx),
    .out_rx_segments     (out_rx_segments)
  );

  assign out_beat = {out_send_kind, out_first_segment, out_segment_count, out_gap_ms,
                     out_session_end, out_deliver_rx, out_rx_segments};

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: check popped beats, stall pop in random bursts
  always @(posedge clk) begin
    if (rst_n && pop && empty === 1'b0) sb.check_result(out_beat);
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (stall_left != 0) begin
      pop        <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && pop_odds != 0 && $urandom_range(1, pop_odds * 4) == 1) begin
      pop        <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      pop <= 1'b1;
    end
    if ($urandom_range(0, 63) == 0) pop_odds <= quiet ? 0 : $urandom_range(0, 3);
  end

  // Hang guard
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  function automatic frame_beat_t random_beat();
    frame_beat_t b;
    b.cmd   = 1'($urandom_range(0, 1));
    b.ftype = 2'($urandom_range(0, 3));
    b.mlen  = 12'($urandom);
    b.seq   = 4'($urandom);
    b.fstat = 2'($urandom_range(0, 3));
    b.bsize = 8'($urandom);
    b.gap   = 8'($urandom);
    b.nseg  = 11'($urandom);
    return b;
  endfunction

  // Fields a beat does not use stay random
  function automatic frame_beat_t rx_frame(logic [1:0] ft, logic [11:0] mlen, logic [3:0] seq);
    frame_beat_t b;
    b       = random_beat();
    b.cmd   = 1'b0;
    b.ftype = ft;
    b.mlen  = mlen;
    b.seq   = seq;
    return b;
  endfunction

  function automatic frame_beat_t flow(logic [1:0] fs, logic [7:0] bs, logic [7:0] gap);
    frame_beat_t b;
    b       = random_beat();
    b.cmd   = 1'b0;
    b.ftype = FT_FLOW;
    b.fstat = fs;
    b.bsize = bs;
    b.gap   = gap;
    return b;
  endfunction

  function automatic frame_beat_t tx_request(logic [1:0] ft, logic [10:0] nseg);
    frame_beat_t b;
    b       = random_beat();
    b.cmd   = 1'b1;
    b.ftype = ft;
    b.nseg  = nseg;
    return b;
  endfunction

  // Push one beat, with an optional idle burst first; push stays high after
  task automatic send_beat(input frame_beat_t b);
    if (idle_odds != 0 && $urandom_range(1, idle_odds * 4) == 1) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_command          <= b.cmd;
    in_frame_type       <= b.ftype;
    in_message_length   <= b.mlen;
    in_seq_num          <= b.seq;
    in_flow_status      <= b.fstat;
    in_block_size       <= b.bsize;
    in_min_sep_time     <= b.gap;
    in_tx_segment_count <= b.nseg;
    push                <= 1'b1;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    sb.note_input(b);
    items_sent++;
  endtask

  // Transmit session: first frame request, then flow control until it closes
  task automatic run_tx_session();
    int unsigned pick;
    logic [10:0] nseg;
    logic [7:0]  bs;
    pick = $urandom_range(0, 99);
    if (pick < 70) nseg = 11'($urandom_range(1, 40));
    else if (pick < 90) nseg = 11'($urandom_range(41, 300));
    else if (pick < 95) nseg = 11'(SEG_LIMIT);
    else nseg = 11'($urandom_range(1, 2047));
    send_beat(tx_request(FT_FIRST, nseg));
    while (sb.mode == S_SEND) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) bs = '0;
      else if ($urandom_range(0, 9) == 0) bs = 8'($urandom_range(1, 255));
      else bs = 8'($urandom_range(1, 16));
      if (pick < 3)
        send_beat(tx_request(2'($urandom_range(0, 3)), 11'($urandom)));
      else if (pick < 12)
        send_beat(rx_frame(2'($urandom_range(0, 2)), 12'($urandom), 4'($urandom)));
      else if (pick < 20)
        send_beat(flow(FS_WAIT, 8'($urandom), 8'($urandom)));
      else if (pick < 23)
        send_beat(flow(FS_OVERFLOW, 8'($urandom), 8'($urandom)));
      else
        send_beat(flow(pick < 33 ? FS_RESERVED : FS_CONT, bs, 8'($urandom)));
    end
  endtask

  // Receive session: first frame, then consecutive frames; some sessions
  // get a broken frame, a bad sequence number or an aborting request
  task automatic run_rx_session();
    int unsigned pick;
    logic [11:0] mlen;
    logic [1:0]  ft;
    logic        clean;
    pick = $urandom_range(0, 99);
    if (pick < 60) mlen = 12'($urandom_range(0, 120));
    else if (pick < 90) mlen = 12'($urandom_range(121, 700));
    else if (pick < 97) mlen = 12'($urandom);
    else mlen = 12'($urandom_range(3000, 4095));
    // only messages up to 700 may run clean, so a clean session stays short
    clean = ($urandom_range(0, 2) == 0) && (mlen <= 12'd700);
    send_beat(rx_frame(FT_FIRST, mlen, 4'($urandom)));
    while (sb.mode == S_RECV) begin
      pick = clean ? 199 : $urandom_range(0, 199);
      ft   = 2'($urandom_range(0, 2));
      if (ft == FT_CONSEC) ft = FT_FLOW;
      if (pick < 2)
        send_beat(tx_request(2'($urandom_range(0, 3)), 11'($urandom)));
      else if (pick < 4)
        send_beat(rx_frame(ft, 12'($urandom), 4'($urandom)));
      else if (pick < 6)
        send_beat(rx_frame(FT_CONSEC, 12'($urandom),
                           sb.rx_seq + 4'd1 + 4'($urandom_range(1, 15))));
      else
        send_beat(rx_frame(FT_CONSEC, 12'($urandom), sb.rx_seq + 4'd1));
    end
  endtask

  initial begin
    int unsigned pick;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle-state errors and singles
    idle_odds = 2;
    send_beat(rx_frame(FT_CONSEC, 12'd0, 4'd0));
    send_beat(rx_frame(FT_SINGLE, 12'hFFF, 4'hF));
    send_beat(tx_request(FT_FIRST, 11'd0));
    send_beat(tx_request(FT_FIRST, 11'(SEG_LIMIT + 1)));
    send_beat(tx_request(FT_SINGLE, 11'h7FF));
    send_beat(tx_request(FT_CONSEC, 11'd5));
    send_beat(tx_request(FT_SINGLE, 11'd7));
    // full-size transmit: wide burst, ignored frames, reserved status sends the rest
    send_beat(tx_request(FT_FIRST, 11'(SEG_LIMIT)));
    send_beat(flow(FS_CONT, 8'hFF, 8'hFF));
    send_beat(rx_frame(FT_CONSEC, 12'd0, 4'd0));
    send_beat(flow(FS_WAIT, 8'd0, 8'd0));
    send_beat(flow(FS_RESERVED, 8'd0, 8'd0));
    // one-segment transmit closes on the first flow control
    send_beat(tx_request(FT_FIRST, 11'd1));
    send_beat(flow(FS_CONT, 8'd0, 8'h5A));
    send_beat(tx_request(FT_FIRST, 11'd10));
    send_beat(flow(FS_OVERFLOW, 8'd3, 8'd0));
    // receives: zero length, sequence mismatch, wrong frame, then a stray consecutive frame and a request
    send_beat(rx_frame(FT_FIRST, 12'd0, 4'd0));
    send_beat(rx_frame(FT_CONSEC, 12'd0, 4'd1));
    send_beat(rx_frame(FT_FIRST, 12'hFFF, 4'd0));
    send_beat(rx_frame(FT_CONSEC, 12'd0, 4'd1));
    send_beat(rx_frame(FT_CONSEC, 12'd0, 4'd5));
    send_beat(rx_frame(FT_FIRST, 12'd20, 4'd0));
    send_beat(rx_frame(FT_FIRST, 12'd20, 4'd0));
    send_beat(rx_frame(FT_CONSEC, 12'd0, 4'd1));
    send_beat(tx_request(FT_SINGLE, 11'd1));

    // Random mix of sessions and stray beats; no idling near the end
    while (items_sent < ITEM_TARGET) begin
      idle_odds = $urandom_range(0, 3);
      if (items_sent > ITEM_TARGET - 150) begin
        idle_odds = 0;
        quiet     = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35)
        run_tx_session();
      else if (pick < 70)
        run_rx_session();
      else if (pick < 75)
        send_beat(rx_frame(FT_SINGLE, 12'($urandom), 4'($urandom)));
      else if (pick < 80)
        send_beat(tx_request(FT_SINGLE, 11'($urandom_range(1, SEG_LIMIT))));
      else if (pick < 90)
        send_beat(tx_request(2'($urandom_range(0, 3)),
                             pick < 85 ? 11'd0 : 11'($urandom_range(SEG_LIMIT + 1, 2047))));
      else
        send_beat(random_beat());
    end

    // Drain
    quiet = 1'b1;
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ctsc_pkg.sv
rtl/ctsc_fifo.sv
rtl/ctsc_front.sv
rtl/ctsc_back.sv
rtl/can_transport_session_control.sv
dv/session_scoreboard.sv
dv/tb.sv
